// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: rtl/core/psec_pkg.sv
package psec_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int SAMPLE_WIDTH = 16;

  localparam int IN_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int INT_W   = 32;
  localparam int DRIVE_W = 32;
  localparam int CFG_IDX_W = 8;

  // error = measured - target needs one more bit than a sample
  localparam int EW  = SAMPLE_WIDTH + 1;
  localparam int AW  = (EW > GAIN_W) ? EW : GAIN_W;
  localparam int BW  = (2 * EW > INT_W) ? 2 * EW : INT_W;
  localparam int PW  = AW + BW;
  localparam int ACW = PW + 2;

  localparam logic [CFG_IDX_W-1:0] REG_KP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KD   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(3);

  localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  typedef struct packed {
    logic                 en;
    logic signed [AW-1:0] a;
    logic signed [BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic update;
    logic clear;
    logic accum;
  } integ_ctl_t;

  // Low SAMPLE_WIDTH bits of a field as a signed value; wider samples zero-fill.
  function automatic logic signed [SAMPLE_WIDTH-1:0] read_sample(input logic [IN_W-1:0] x);
    logic [SAMPLE_WIDTH+IN_W-1:0] t;
    t = {{SAMPLE_WIDTH{1'b0}}, x};
    return signed'(t[SAMPLE_WIDTH-1:0]);
  endfunction

endpackage

// File: rtl/core/psec_mul.sv
module psec_mul
  import psec_pkg::*;
(
  input  logic                 clk_i,
  input  mul_req_t             req_i,
  output logic signed [PW-1:0] prod_o
);

  logic signed [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= PW'($signed(req_i.a)) * PW'($signed(req_i.b));
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/psec_integ.sv
module psec_integ
  import psec_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  integ_ctl_t              ctl_i,
  input  logic signed [EW-1:0]    err_i,
  output logic signed [INT_W-1:0] sum_o,
  output logic                    clip_o
);

  logic signed [INT_W-1:0] sum_q, sum_d;
  logic signed [INT_W-1:0] base;
  logic signed [INT_W:0]   raw;
  logic                    ovf;
  logic signed [INT_W-1:0] clamped;

  always_comb begin
    base    = ctl_i.clear ? '0 : sum_q;
    raw     = {base[INT_W-1], base} + {{(INT_W+1-EW){err_i[EW-1]}}, err_i};
    ovf     = raw[INT_W] != raw[INT_W-1];
    clamped = ovf ? (raw[INT_W] ? INT_MIN : INT_MAX) : raw[INT_W-1:0];
    sum_d   = sum_q;
    if (ctl_i.update) begin
      if (ctl_i.accum) begin
        sum_d = clamped;
      end else if (ctl_i.clear) begin
        sum_d = '0;
      end
    end
    clip_o = ctl_i.update & ctl_i.accum & ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: rtl/core/pid_square_error_controller.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: measured, target, derivative
//                                                tuser: clear_integral
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: drive; tuser: saturated
// cfg       in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// An item goes, from acceptance to the next possible acceptance, through one
// integral update, four passes through the shared signed multiplier (error
// square, then kp, ki and kd terms, summed from the product register) and one
// saturation step. The result register lets the next item in while a result
// waits; the sequencer holds in its last step only while that result is untaken.
// Reset clears gains, mode, integral and handshake state. cfg is always ready.
module pid_square_error_controller
  import psec_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // measured[15:0], target[31:16], derivative[47:32]
  input  logic [0:0]           s_axis_tuser,  // clear_integral[0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // drive[31:0]
  output logic [0:0]           m_axis_tuser,  // saturated[0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INTEG = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_P     = 3'd3;
  localparam logic [2:0] S_I     = 3'd4;
  localparam logic [2:0] S_D     = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic                     mode_q;

  logic signed [EW-1:0]           e_q;
  logic signed [SAMPLE_WIDTH-1:0] der_q;
  logic                           clr_q;
  logic                           clip_q;
  logic signed [ACW-1:0]          acc_q, acc_d;

  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      sat_q;

  mul_req_t                mul_req;
  logic signed [PW-1:0]    prod;
  integ_ctl_t              integ_ctl;
  logic signed [INT_W-1:0] integ_sum;
  logic                    integ_clip;

  logic signed [EW-1:0]      abs_e;
  logic signed [ACW-1:0]     shifted;
  logic                      drive_ovf;
  logic signed [DRIVE_W-1:0] drive_sat;
  logic                      in_acc, out_load;

  psec_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  psec_integ u_integ (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (integ_ctl),
    .err_i  (e_q),
    .sum_o  (integ_sum),
    .clip_o (integ_clip)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign integ_ctl.update = (state_q == S_INTEG);
  assign integ_ctl.clear  = clr_q;
  assign integ_ctl.accum  = mode_q;

  assign abs_e = e_q[EW-1] ? -e_q : e_q;

  // operand selection for the shared multiplier
  always_comb begin
    mul_req.en = 1'b1;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      S_INTEG: begin
        mul_req.a = AW'(e_q);
        mul_req.b = BW'(abs_e);
      end
      S_SQ: begin
        mul_req.a = AW'(kp_q);
        mul_req.b = mode_q ? prod[BW-1:0] : BW'(e_q);
      end
      S_P: begin
        mul_req.a = AW'(ki_q);
        mul_req.b = BW'(integ_sum);
      end
      S_I: begin
        mul_req.a = AW'(kd_q);
        mul_req.b = BW'(der_q);
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  // floor shift, then clip to the drive range
  always_comb begin
    shifted   = acc_q >>> FRAC_BITS;
    drive_ovf = !((&shifted[ACW-1:DRIVE_W-1]) || ~(|shifted[ACW-1:DRIVE_W-1]));
    drive_sat = drive_ovf ? (shifted[ACW-1] ? DRIVE_MIN : DRIVE_MAX)
                          : shifted[DRIVE_W-1:0];
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_INTEG;
      S_INTEG: state_d = S_SQ;
      S_SQ: begin
        acc_d   = '0;
        state_d = S_P;
      end
      S_P: begin
        acc_d   = acc_q + ACW'(prod);
        state_d = S_I;
      end
      S_I: begin
        acc_d   = acc_q + ACW'(prod);
        state_d = S_D;
      end
      S_D: begin
        acc_d   = acc_q + ACW'(prod);
        state_d = S_OUT;
      end
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      mode_q      <= 1'b0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_KP:   kp_q   <= signed'(cfg_data_i);
          REG_KI:   ki_q   <= signed'(cfg_data_i);
          REG_KD:   kd_q   <= signed'(cfg_data_i);
          REG_MODE: mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        clip_q <= 1'b0;
      end else if (state_q == S_INTEG) begin
        clip_q <= integ_clip;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_acc) begin
      e_q   <= EW'(read_sample(s_axis_tdata[15:0])) - EW'(read_sample(s_axis_tdata[31:16]));
      der_q <= read_sample(s_axis_tdata[47:32]);
      clr_q <= s_axis_tuser[0];
    end
    if (out_load) begin
      drive_q <= drive_sat;
      sat_q   <= clip_q | drive_ovf;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = drive_q;
  assign m_axis_tuser[0] = sat_q;

endmodule

// File: rtl/core/psec_checker.sv
`include "assert_macros.svh"

module psec_checker
  import psec_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a waiting result must not change under the consumer
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // one item at a time: busy right after an accept
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted while busy")

  // a new result only comes out of a running item
  `ASSERT_PROP(a_result_from_work, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without work in flight")

  // no result can appear in the first cycle after an accept
  `ASSERT_NEVER(a_no_early_result, clk_i, rst_ni, $past(s_axis_tvalid && s_axis_tready) && $rose(m_axis_tvalid), "result too early")

endmodule

bind pid_square_error_controller psec_checker u_psec_checker (.*);

// File: tb/pid_square_error_controller_tb.sv
module pid_square_error_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psec_pkg::*;

  localparam int RUN_LIMIT    = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int WIND_ITEMS   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = {CFG_IDX_W{1'b1}};

  typedef struct {
    logic signed [15:0] measured;
    logic signed [15:0] target;
    logic signed [15:0] derivative;
    logic               clear;
  } sample_t;

  typedef struct {
    logic signed [31:0] drive;
    logic               sat;
  } drive_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;  // measured[15:0], target[31:16], derivative[47:32]
  logic [0:0]           s_axis_tuser = '0;  // clear_integral[0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;       // drive[31:0]
  logic [0:0]           m_axis_tuser;       // saturated[0]
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0]          cfg_data_i = '0;

  pid_square_error_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the controller state
  longint gain_kp = 0;
  longint gain_ki = 0;
  longint gain_kd = 0;
  longint integ   = 0;
  bit     sq_mode = 1'b0;

  sample_t     sample_q[$];
  drive_t      drive_expect_q[$];
  sample_t     in_flight;
  bit          in_taken = 1'b0;
  int unsigned errs = 0;
  int unsigned cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  function automatic drive_t step_pid(sample_t s);
    longint meas, targ, der, e, pe, acc, d;
    drive_t r;
    meas = longint'(s.measured);
    targ = longint'(s.target);
    der  = longint'(s.derivative);
    r.sat = 1'b0;
    if (s.clear) integ = 0;
    e = meas - targ;
    if (sq_mode) begin
      acc = integ + e;
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
        r.sat = 1'b1;
      end
      if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
        r.sat = 1'b1;
      end
      integ = acc;
      pe = (e < 0) ? -(e * e) : e * e;
    end else begin
      pe = e;
    end
    // products stay below 2^48, so the sum cannot leave 64 bits
    acc = gain_kp * pe + gain_ki * integ + gain_kd * der;
    d = acc >>> FRAC_BITS;
    if (d > 64'sd2147483647) begin
      d = 64'sd2147483647;
      r.sat = 1'b1;
    end
    if (d < -64'sd2147483648) begin
      d = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.drive = d[31:0];
    return r;
  endfunction

  // input acceptance feeds the predictor; output acceptance is checked
  always @(posedge clk_i) begin : scoreboard
    drive_t want;
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_taken) drive_expect_q.push_back(step_pid(in_flight));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_expect_q.size() == 0) begin
        errs++;
        if (errs <= 10)
          $display("unexpected item: drive %0d sat %0b", $signed(m_axis_tdata), m_axis_tuser[0]);
      end else begin
        want = drive_expect_q.pop_front();
        if (m_axis_tdata !== want.drive || m_axis_tuser[0] !== want.sat) begin
          errs++;
          if (errs <= 10)
            $display("bad item: drive %0d sat %0b, wanted drive %0d sat %0b",
                     $signed(m_axis_tdata), m_axis_tuser[0], want.drive, want.sat);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_flight = sample_q.pop_front();
        s_axis_tdata  <= {in_flight.derivative, in_flight.target, in_flight.measured};
        s_axis_tuser  <= in_flight.clear;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack++;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("pid_square_error_controller: mismatch");
      $finish;
    end
  end

  task automatic push(logic [15:0] meas, logic [15:0] targ, logic [15:0] der, logic clr);
    sample_t s;
    s.measured   = meas;
    s.target     = targ;
    s.derivative = der;
    s.clear      = clr;
    sample_q.push_back(s);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KP:   gain_kp = longint'($signed(data));
      REG_KI:   gain_ki = longint'($signed(data));
      REG_KD:   gain_kd = longint'($signed(data));
      REG_MODE: sq_mode = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd, logic [15:0] mode);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_MODE, mode);
  endtask

  // wait until every queued item has produced its result, then let the pipe settle
  task automatic settle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || drive_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_field();
    logic [15:0] corner_vals [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(511)) - 16'd256;
      2: return corner_vals[$urandom_range(3)];
      default: return 16'($urandom_range(15)) - 16'd8;
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      1: return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // gains still at their reset values
    push(16'h1234, 16'hfedc, 16'h7fff, 1'b0);
    push(16'h8000, 16'h7fff, 16'h8000, 1'b0);
    push(16'h0001, 16'h0000, 16'hffff, 1'b1);
    settle();

    // square mode, unit proportional gain
    set_gains(16'h0100, 16'h0010, 16'h0080, 16'h0001);
    push(16'h0000, 16'h0000, 16'h0000, 1'b0);
    push(16'h7fff, 16'h8000, 16'h0000, 1'b0);
    push(16'h8000, 16'h7fff, 16'h0000, 1'b0);
    push(16'h0005, 16'h0007, 16'h0000, 1'b0);
    push(16'h0000, 16'h0000, 16'h7fff, 1'b0);
    push(16'h0000, 16'h0000, 16'h8000, 1'b0);
    push(16'hffff, 16'hffff, 16'hffff, 1'b1);  // floor of a small negative sum
    push(16'h0001, 16'h0000, 16'h0001, 1'b0);
    push(16'h0000, 16'h0001, 16'h0000, 1'b0);
    push(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    settle();

    // linear mode reads the held integral; junk above the mode bit
    write_reg(REG_MODE, 16'h0002);
    write_reg(REG_UNUSED, 16'hffff);
    push(16'h7fff, 16'h8000, 16'h8000, 1'b0);
    push(16'h0003, 16'h0000, 16'h0000, 1'b1);  // clear while linear
    push(16'h8000, 16'h7fff, 16'h7fff, 1'b0);
    push(16'hffff, 16'h0000, 16'h0000, 1'b0);
    settle();

    // wind the integral up, then down, at the largest error
    set_gains(16'h0001, 16'h0001, 16'h0000, 16'h0001);
    push(16'h7fff, 16'h8000, 16'h0000, 1'b1);
    repeat (WIND_ITEMS) push(16'h7fff, 16'h8000, 16'h0000, 1'b0);
    settle();
    push(16'h8000, 16'h7fff, 16'h0000, 1'b1);
    repeat (WIND_ITEMS) push(16'h8000, 16'h7fff, 16'h0000, 1'b0);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (p == 0)
        set_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h0001);
      else if (p == 1)
        set_gains(16'h8000, 16'h8000, 16'h8000, 16'hfffe);
      else
        set_gains(rand_gain(), rand_gain(), rand_gain(), 16'($urandom));
      // long receiver hold-off while the sender keeps offering
      if (p == 2) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) settle();
        push(rand_field(), rand_field(), rand_field(), $urandom_range(15) == 0);
      end
      settle();
    end

    if (errs == 0 && drive_expect_q.size() == 0)
      $display("pid_square_error_controller: match");
    else
      $display("pid_square_error_controller: mismatch");
    $finish;
  end

endmodule
